### rtl/thct_pkg.sv
// Shared types, sizes and the microcode table for the timing hit-count table.
// Depends on nothing; used by timing_hit_count_table_core.
package thct_pkg;

    localparam int TABLE_ENTRIES = 32;
    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

    typedef struct packed {
        logic [15:0] offset;
        logic [7:0]  width;
        logic [31:0] count;
    } entry_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ADD_INIT,
        ST_ADD_RD,
        ST_ADD_CMP,
        ST_ADD_HIT,
        ST_ADD_MISS,
        ST_SORT_INIT,
        ST_SORT_EMPTY,
        ST_I_RD,
        ST_I_LOAD,
        ST_J_RD,
        ST_J_SKIP,
        ST_J_CMP,
        ST_I_END,
        ST_DUMP_RD,
        ST_DUMP_OUT
    } step_t;

    typedef enum logic [3:0] {
        C_NONE,
        C_ACC_ADD,
        C_ACC_SORT,
        C_FILL_ZERO,
        C_MATCH,
        C_JLAST,
        C_J_EQ_I,
        C_ILAST
    } cond_t;

    typedef enum logic {RS_J, RS_I} rsel_t;
    typedef enum logic [1:0] {WE_NONE, WE_ALWAYS, WE_GT, WE_NOTFULL} we_t;
    typedef enum logic [1:0] {WA_J, WA_I, WA_FILL} wa_t;
    typedef enum logic [1:0] {WD_HIT, WD_NEW, WD_ENT} wd_t;
    typedef enum logic [1:0] {J_HOLD, J_ZERO, J_INC, J_INC_NOA} jop_t;
    typedef enum logic [1:0] {I_HOLD, I_ZERO, I_INC} iop_t;
    typedef enum logic [1:0] {E_HOLD, E_LOAD, E_LOAD_GT} eop_t;
    typedef enum logic [1:0] {O_HIT, O_NEW, O_EMPTY, O_DUMP} osel_t;

    typedef struct packed {
        logic  take;
        cond_t cond_a;
        step_t tgt_a;
        cond_t cond_b;
        step_t tgt_b;
        step_t tgt_else;
        logic  rd_en;
        rsel_t rd_sel;
        we_t   we;
        wa_t   wa_sel;
        wd_t   wd_sel;
        jop_t  j_op;
        iop_t  i_op;
        eop_t  ent_op;
        logic  fill_inc;
        logic  emit;
        osel_t out_sel;
    } ctrl_t;

    // Microprogram: one control word per step.
    function automatic ctrl_t ucode(step_t s);
        ctrl_t c;
        c = '0;
        unique case (s)
            ST_IDLE: begin
                c.take     = 1'b1;
                c.cond_a   = C_ACC_ADD;
                c.tgt_a    = ST_ADD_INIT;
                c.cond_b   = C_ACC_SORT;
                c.tgt_b    = ST_SORT_INIT;
                c.tgt_else = ST_IDLE;
            end
            ST_ADD_INIT: begin
                c.j_op     = J_ZERO;
                c.cond_a   = C_FILL_ZERO;
                c.tgt_a    = ST_ADD_MISS;
                c.tgt_else = ST_ADD_RD;
            end
            ST_ADD_RD: begin
                c.rd_en    = 1'b1;
                c.rd_sel   = RS_J;
                c.tgt_else = ST_ADD_CMP;
            end
            ST_ADD_CMP: begin
                c.j_op     = J_INC_NOA;
                c.cond_a   = C_MATCH;
                c.tgt_a    = ST_ADD_HIT;
                c.cond_b   = C_JLAST;
                c.tgt_b    = ST_ADD_MISS;
                c.tgt_else = ST_ADD_RD;
            end
            ST_ADD_HIT: begin
                c.emit     = 1'b1;
                c.out_sel  = O_HIT;
                c.we       = WE_ALWAYS;
                c.wa_sel   = WA_J;
                c.wd_sel   = WD_HIT;
                c.tgt_else = ST_IDLE;
            end
            ST_ADD_MISS: begin
                c.emit     = 1'b1;
                c.out_sel  = O_NEW;
                c.we       = WE_NOTFULL;
                c.wa_sel   = WA_FILL;
                c.wd_sel   = WD_NEW;
                c.fill_inc = 1'b1;
                c.tgt_else = ST_IDLE;
            end
            ST_SORT_INIT: begin
                c.i_op     = I_ZERO;
                c.j_op     = J_ZERO;
                c.cond_a   = C_FILL_ZERO;
                c.tgt_a    = ST_SORT_EMPTY;
                c.tgt_else = ST_I_RD;
            end
            ST_SORT_EMPTY: begin
                c.emit     = 1'b1;
                c.out_sel  = O_EMPTY;
                c.tgt_else = ST_IDLE;
            end
            ST_I_RD: begin
                c.rd_en    = 1'b1;
                c.rd_sel   = RS_I;
                c.j_op     = J_ZERO;
                c.tgt_else = ST_I_LOAD;
            end
            ST_I_LOAD: begin
                c.ent_op   = E_LOAD;
                c.tgt_else = ST_J_RD;
            end
            ST_J_RD: begin
                c.rd_en    = 1'b1;
                c.rd_sel   = RS_J;
                c.cond_a   = C_J_EQ_I;
                c.tgt_a    = ST_J_SKIP;
                c.tgt_else = ST_J_CMP;
            end
            ST_J_SKIP: begin
                c.j_op     = J_INC;
                c.cond_a   = C_JLAST;
                c.tgt_a    = ST_I_END;
                c.tgt_else = ST_J_RD;
            end
            ST_J_CMP: begin
                c.we       = WE_GT;
                c.wa_sel   = WA_J;
                c.wd_sel   = WD_ENT;
                c.ent_op   = E_LOAD_GT;
                c.j_op     = J_INC;
                c.cond_a   = C_JLAST;
                c.tgt_a    = ST_I_END;
                c.tgt_else = ST_J_RD;
            end
            ST_I_END: begin
                c.we       = WE_ALWAYS;
                c.wa_sel   = WA_I;
                c.wd_sel   = WD_ENT;
                c.i_op     = I_INC;
                c.j_op     = J_ZERO;
                c.cond_a   = C_ILAST;
                c.tgt_a    = ST_DUMP_RD;
                c.tgt_else = ST_I_RD;
            end
            ST_DUMP_RD: begin
                c.rd_en    = 1'b1;
                c.rd_sel   = RS_J;
                c.tgt_else = ST_DUMP_OUT;
            end
            ST_DUMP_OUT: begin
                c.emit     = 1'b1;
                c.out_sel  = O_DUMP;
                c.j_op     = J_INC;
                c.cond_a   = C_JLAST;
                c.tgt_a    = ST_IDLE;
                c.tgt_else = ST_DUMP_RD;
            end
            default: begin
                c.tgt_else = ST_IDLE;
            end
        endcase
        return c;
    endfunction

    // Table position as carried on the 5-bit index field.
    function automatic logic [4:0] idx5(logic [IDX_W-1:0] v);
        logic [IDX_W+4:0] w;
        w = {5'd0, v};
        return w[4:0];
    endfunction

    // Fill level as carried on the 6-bit fill field.
    function automatic logic [5:0] fill6(logic [CNT_W-1:0] v);
        logic [CNT_W+5:0] w;
        w = {6'd0, v};
        return w[5:0];
    endfunction

endpackage

### rtl/timing_hit_count_table_core.sv
// Timing hit-count table: microcoded sequencer, entry memory and result register.
// Depends on thct_pkg (types, sizes, microcode table).
//
// Use: s_ carries one request (kind, timing_offset, pulse_width) per valid/ready
// handshake; m_ returns result items through a single output register.
// An add request (kind 0) searches the n filled entries in order, each read
// through the one-read-port entry memory and then compared, and returns one
// result: a hit (count incremented, saturating), an append with count 1, or
// table full. A sort request (kind 1) runs the i/j compare-and-swap pass over
// the filled entries, then dumps the n entries in order, last marking the
// final one. An empty table gives a single result with last set.
// One request is worked at a time; s_ready is high only while the sequencer
// sits at its idle step, which it reaches once the final result is registered.
// A stalled receiver holds the sequencer at its emit step; nothing is dropped.
// Reset (aresetn low, synchronous) empties the table and drops any pending
// result. The entry memory is not cleared; entries past the fill level are
// never read.
module timing_hit_count_table_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_kind,
    input  logic [15:0] s_timing_offset,
    input  logic [7:0]  s_pulse_width,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_status,
    output logic        m_matched,
    output logic [4:0]  m_entry_index,
    output logic        m_entry_valid,
    output logic [15:0] m_entry_offset,
    output logic [7:0]  m_entry_width,
    output logic [31:0] m_entry_count,
    output logic [5:0]  m_fill_count,
    output logic        m_last
);

    localparam int IDX_W = thct_pkg::IDX_W;
    localparam int CNT_W = thct_pkg::CNT_W;

    typedef struct packed {
        logic acc_add;
        logic acc_sort;
        logic fill_zero;
        logic match;
        logic jlast;
        logic j_eq_i;
        logic ilast;
    } cflags_t;

    function automatic logic cond_eval(thct_pkg::cond_t c, cflags_t f);
        logic r;
        unique case (c)
            thct_pkg::C_NONE:      r = 1'b0;
            thct_pkg::C_ACC_ADD:   r = f.acc_add;
            thct_pkg::C_ACC_SORT:  r = f.acc_sort;
            thct_pkg::C_FILL_ZERO: r = f.fill_zero;
            thct_pkg::C_MATCH:     r = f.match;
            thct_pkg::C_JLAST:     r = f.jlast;
            thct_pkg::C_J_EQ_I:    r = f.j_eq_i;
            thct_pkg::C_ILAST:     r = f.ilast;
            default:               r = 1'b0;
        endcase
        return r;
    endfunction

    thct_pkg::step_t  upc_reg, upc_next;
    thct_pkg::ctrl_t  cw;
    cflags_t          flags;

    logic [IDX_W-1:0] i_reg, i_next;
    logic [IDX_W-1:0] j_reg, j_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic [15:0]      key_off_reg;
    logic [7:0]       key_wid_reg;
    thct_pkg::entry_t ent_reg, ent_next;

    thct_pkg::entry_t mem [thct_pkg::TABLE_ENTRIES];
    thct_pkg::entry_t rd_reg;
    logic [IDX_W-1:0] rd_addr;
    logic [IDX_W-1:0] wr_addr;
    thct_pkg::entry_t wr_data;
    logic             wr_en;

    logic             adv;
    logic             full;
    logic             gt;
    logic             jump_a;
    logic [31:0]      hit_count;

    logic             m_valid_reg;
    logic             m_status_reg, m_matched_reg, m_entry_valid_reg, m_last_reg;
    logic [4:0]       m_entry_index_reg;
    logic [15:0]      m_entry_offset_reg;
    logic [7:0]       m_entry_width_reg;
    logic [31:0]      m_entry_count_reg;
    logic [5:0]       m_fill_count_reg;

    assign cw      = thct_pkg::ucode(upc_reg);
    assign s_ready = cw.take;
    // an emit step holds until the output register is free
    assign adv     = !(cw.emit && m_valid_reg && !m_ready);

    assign full      = (fill_reg == CNT_W'(thct_pkg::TABLE_ENTRIES));
    assign gt        = (ent_reg.count > rd_reg.count);
    assign hit_count = (rd_reg.count == 32'hFFFF_FFFF) ? rd_reg.count
                                                       : rd_reg.count + 32'd1;

    always_comb begin
        flags.acc_add   = s_valid && !s_kind;
        flags.acc_sort  = s_valid && s_kind;
        flags.fill_zero = (fill_reg == '0);
        flags.match     = (rd_reg.offset == key_off_reg) && (rd_reg.width == key_wid_reg);
        flags.jlast     = ((CNT_W'(j_reg) + CNT_W'(1)) == fill_reg);
        flags.j_eq_i    = (j_reg == i_reg);
        flags.ilast     = ((CNT_W'(i_reg) + CNT_W'(1)) == fill_reg);
    end

    assign jump_a = cond_eval(cw.cond_a, flags);

    always_comb begin
        if (!adv) begin
            upc_next = upc_reg;
        end else if (jump_a) begin
            upc_next = cw.tgt_a;
        end else if (cond_eval(cw.cond_b, flags)) begin
            upc_next = cw.tgt_b;
        end else begin
            upc_next = cw.tgt_else;
        end
    end

    // Datapath controls
    always_comb begin
        i_next    = i_reg;
        j_next    = j_reg;
        fill_next = fill_reg;
        ent_next  = ent_reg;
        if (adv) begin
            case (cw.i_op)
                thct_pkg::I_ZERO: i_next = '0;
                thct_pkg::I_INC:  i_next = i_reg + IDX_W'(1);
                default:          i_next = i_reg;
            endcase
            case (cw.j_op)
                thct_pkg::J_ZERO:    j_next = '0;
                thct_pkg::J_INC:     j_next = j_reg + IDX_W'(1);
                thct_pkg::J_INC_NOA: j_next = jump_a ? j_reg : j_reg + IDX_W'(1);
                default:             j_next = j_reg;
            endcase
            case (cw.ent_op)
                thct_pkg::E_LOAD:    ent_next = rd_reg;
                thct_pkg::E_LOAD_GT: ent_next = gt ? rd_reg : ent_reg;
                default:             ent_next = ent_reg;
            endcase
            if (cw.fill_inc && !full) begin
                fill_next = fill_reg + CNT_W'(1);
            end
        end
    end

    always_comb begin
        rd_addr = (cw.rd_sel == thct_pkg::RS_I) ? i_reg : j_reg;
        case (cw.wa_sel)
            thct_pkg::WA_I:    wr_addr = i_reg;
            thct_pkg::WA_FILL: wr_addr = fill_reg[IDX_W-1:0];
            default:           wr_addr = j_reg;
        endcase
        case (cw.wd_sel)
            thct_pkg::WD_HIT: wr_data = '{offset: rd_reg.offset, width: rd_reg.width,
                                          count: hit_count};
            thct_pkg::WD_NEW: wr_data = '{offset: key_off_reg, width: key_wid_reg,
                                          count: 32'd1};
            default:          wr_data = ent_reg;
        endcase
        case (cw.we)
            thct_pkg::WE_ALWAYS:  wr_en = adv;
            thct_pkg::WE_GT:      wr_en = adv && gt;
            thct_pkg::WE_NOTFULL: wr_en = adv && !full;
            default:              wr_en = 1'b0;
        endcase
    end

    // Entry memory: one write, one registered read per cycle
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (cw.rd_en && adv) begin
            rd_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upc_reg     <= thct_pkg::ST_IDLE;
            fill_reg    <= '0;
            i_reg       <= '0;
            j_reg       <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            upc_reg  <= upc_next;
            fill_reg <= fill_next;
            i_reg    <= i_next;
            j_reg    <= j_next;
            if (cw.emit && adv) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        ent_reg <= ent_next;
        if (s_valid && s_ready) begin
            key_off_reg <= s_timing_offset;
            key_wid_reg <= s_pulse_width;
        end
        if (cw.emit && adv) begin
            m_status_reg       <= 1'b0;
            m_matched_reg      <= 1'b0;
            m_entry_valid_reg  <= 1'b1;
            m_last_reg         <= 1'b1;
            m_entry_index_reg  <= thct_pkg::idx5(j_reg);
            m_entry_offset_reg <= rd_reg.offset;
            m_entry_width_reg  <= rd_reg.width;
            m_entry_count_reg  <= rd_reg.count;
            m_fill_count_reg   <= thct_pkg::fill6(fill_reg);
            case (cw.out_sel)
                thct_pkg::O_HIT: begin
                    m_matched_reg     <= 1'b1;
                    m_entry_count_reg <= hit_count;
                end
                thct_pkg::O_NEW: begin
                    if (full) begin
                        m_status_reg       <= 1'b1;
                        m_entry_valid_reg  <= 1'b0;
                        m_entry_index_reg  <= '0;
                        m_entry_offset_reg <= '0;
                        m_entry_width_reg  <= '0;
                        m_entry_count_reg  <= '0;
                    end else begin
                        m_entry_index_reg  <= thct_pkg::idx5(fill_reg[IDX_W-1:0]);
                        m_entry_offset_reg <= key_off_reg;
                        m_entry_width_reg  <= key_wid_reg;
                        m_entry_count_reg  <= 32'd1;
                        m_fill_count_reg   <= thct_pkg::fill6(fill_reg + CNT_W'(1));
                    end
                end
                thct_pkg::O_EMPTY: begin
                    m_entry_valid_reg  <= 1'b0;
                    m_entry_index_reg  <= '0;
                    m_entry_offset_reg <= '0;
                    m_entry_width_reg  <= '0;
                    m_entry_count_reg  <= '0;
                end
                default: begin
                    m_last_reg <= flags.jlast;
                end
            endcase
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_matched     = m_matched_reg;
    assign m_entry_index = m_entry_index_reg;
    assign m_entry_valid = m_entry_valid_reg;
    assign m_entry_offset = m_entry_offset_reg;
    assign m_entry_width = m_entry_width_reg;
    assign m_entry_count = m_entry_count_reg;
    assign m_fill_count  = m_fill_count_reg;
    assign m_last        = m_last_reg;

`ifndef SYNTH
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= CNT_W'(thct_pkg::TABLE_ENTRIES))
        else $error("fill level above table size");

    a_hit_keeps_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        (upc_reg == thct_pkg::ST_ADD_HIT) |=> $stable(fill_reg))
        else $error("fill level changed on a hit");

    a_append_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (upc_reg == thct_pkg::ST_ADD_MISS && adv && !full)
        |=> fill_reg == $past(fill_reg) + CNT_W'(1))
        else $error("append did not grow the table");

    a_scan_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (upc_reg == thct_pkg::ST_ADD_CMP || upc_reg == thct_pkg::ST_J_CMP ||
         upc_reg == thct_pkg::ST_DUMP_OUT)
        |-> CNT_W'(j_reg) < fill_reg)
        else $error("scan pointer past fill level");

    a_row_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (upc_reg == thct_pkg::ST_I_LOAD || upc_reg == thct_pkg::ST_I_END)
        |-> CNT_W'(i_reg) < fill_reg)
        else $error("sort row past fill level");
`endif

endmodule

### verif/timing_hit_count_table_core_test.sv
// Self-checking testbench for timing_hit_count_table_core: add and sort/dump requests,
// checked result by result against an in-bench model of the hit-count table.
// Depends on thct_pkg and timing_hit_count_table_core.
module timing_hit_count_table_core_test;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int LONG_HOLD      = 400;
    localparam int TAIL_CYCLES    = 100;
    localparam int RANDOM_ITEMS   = 220;

    localparam logic KIND_ADD    = 1'b0;
    localparam logic KIND_SORT   = 1'b1;
    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    typedef enum int {RX_OPEN, RX_RANDOM, RX_EVERY_THIRD} rx_mode_t;

    typedef struct packed {
        logic        kind;
        logic [15:0] offset;
        logic [7:0]  width;
    } pair_req_t;

    typedef struct packed {
        logic        status;
        logic        matched;
        logic [4:0]  index;
        logic        valid;
        logic [15:0] offset;
        logic [7:0]  width;
        logic [31:0] count;
        logic [5:0]  fill;
        logic        last;
    } table_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_kind = 1'b0;
    logic [15:0] s_timing_offset = '0;
    logic [7:0]  s_pulse_width = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_status;
    logic        m_matched;
    logic [4:0]  m_entry_index;
    logic        m_entry_valid;
    logic [15:0] m_entry_offset;
    logic [7:0]  m_entry_width;
    logic [31:0] m_entry_count;
    logic [5:0]  m_fill_count;
    logic        m_last;

    timing_hit_count_table_core u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_kind          (s_kind),
        .s_timing_offset (s_timing_offset),
        .s_pulse_width   (s_pulse_width),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_matched       (m_matched),
        .m_entry_index   (m_entry_index),
        .m_entry_valid   (m_entry_valid),
        .m_entry_offset  (m_entry_offset),
        .m_entry_width   (m_entry_width),
        .m_entry_count   (m_entry_count),
        .m_fill_count    (m_fill_count),
        .m_last          (m_last)
    );

    always #10 aclk = ~aclk;

    // Table model
    logic [15:0] tbl_offset [thct_pkg::TABLE_ENTRIES];
    logic [7:0]  tbl_width  [thct_pkg::TABLE_ENTRIES];
    logic [31:0] tbl_count  [thct_pkg::TABLE_ENTRIES];
    int          tbl_used = 0;

    pair_req_t   req_q[$];
    table_row_t  rows_due[$];

    int taken_cnt = 0;
    int idle_run  = 0;
    int err_cnt   = 0;
    bit took      = 1'b0;

    function automatic table_row_t make_row(logic st, logic hit, int idx, logic valid,
                                            logic last);
        table_row_t r;
        r = '0;
        r.status  = st;
        r.matched = hit;
        r.fill    = tbl_used[5:0];
        r.last    = last;
        if (valid) begin
            r.valid  = 1'b1;
            r.index  = idx[4:0];
            r.offset = tbl_offset[idx];
            r.width  = tbl_width[idx];
            r.count  = tbl_count[idx];
        end
        return r;
    endfunction

    task automatic update_table(pair_req_t req);
        int hit;
        int i;
        int j;
        logic [15:0] t_off;
        logic [7:0]  t_wid;
        logic [31:0] t_cnt;
        if (req.kind == KIND_ADD) begin
            hit = -1;
            for (i = 0; i < tbl_used; i++)
                if (hit < 0 && tbl_offset[i] == req.offset && tbl_width[i] == req.width)
                    hit = i;
            if (hit >= 0) begin
                if (tbl_count[hit] != 32'hFFFF_FFFF)
                    tbl_count[hit]++;
                rows_due.push_back(make_row(STATUS_OK, 1'b1, hit, 1'b1, 1'b1));
            end else if (tbl_used >= thct_pkg::TABLE_ENTRIES) begin
                rows_due.push_back(make_row(STATUS_FULL, 1'b0, 0, 1'b0, 1'b1));
            end else begin
                tbl_offset[tbl_used] = req.offset;
                tbl_width[tbl_used]  = req.width;
                tbl_count[tbl_used]  = 32'd1;
                tbl_used++;
                rows_due.push_back(make_row(STATUS_OK, 1'b0, tbl_used - 1, 1'b1, 1'b1));
            end
        end else begin
            // full i/j pass, swap whenever the row-i count beats the column-j count
            for (i = 0; i < tbl_used; i++)
                for (j = 0; j < tbl_used; j++)
                    if (tbl_count[i] > tbl_count[j]) begin
                        t_off = tbl_offset[i];
                        t_wid = tbl_width[i];
                        t_cnt = tbl_count[i];
                        tbl_offset[i] = tbl_offset[j];
                        tbl_width[i]  = tbl_width[j];
                        tbl_count[i]  = tbl_count[j];
                        tbl_offset[j] = t_off;
                        tbl_width[j]  = t_wid;
                        tbl_count[j]  = t_cnt;
                    end
            if (tbl_used == 0)
                rows_due.push_back(make_row(STATUS_OK, 1'b0, 0, 1'b0, 1'b1));
            else
                for (i = 0; i < tbl_used; i++)
                    rows_due.push_back(make_row(STATUS_OK, 1'b0, i, 1'b1,
                                                (i == tbl_used - 1)));
        end
    endtask

    task automatic report_mismatch(string msg);
        $display("ERROR: %s", msg);
        err_cnt++;
    endtask

    task automatic compare_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
    endtask

    // Request acceptance, result checking and watchdog
    always @(posedge aclk) begin
        table_row_t got;
        table_row_t want;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                update_table({s_kind, s_timing_offset, s_pulse_width});
                taken_cnt++;
                took = 1'b1;
            end
            if (m_valid && m_ready) begin
                got = {m_status, m_matched, m_entry_index, m_entry_valid, m_entry_offset,
                       m_entry_width, m_entry_count, m_fill_count, m_last};
                if (rows_due.size() == 0) begin
                    report_mismatch($sformatf("unexpected result, index %0d", got.index));
                end else begin
                    want = rows_due.pop_front();
                    compare_field("status", 32'(got.status), 32'(want.status));
                    compare_field("matched", 32'(got.matched), 32'(want.matched));
                    compare_field("entry_index", 32'(got.index), 32'(want.index));
                    compare_field("entry_valid", 32'(got.valid), 32'(want.valid));
                    compare_field("entry_offset", 32'(got.offset), 32'(want.offset));
                    compare_field("entry_width", 32'(got.width), 32'(want.width));
                    compare_field("entry_count", got.count, want.count);
                    compare_field("fill_count", 32'(got.fill), 32'(want.fill));
                    compare_field("last", 32'(got.last), 32'(want.last));
                end
            end
            if ((s_valid && s_ready) || (m_valid && m_ready))
                idle_run = 0;
            else
                idle_run++;
            if (idle_run >= WATCHDOG_LIMIT) begin
                $display("timeout: no handshake for %0d cycles", idle_run);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // Request driver: bursts of random length separated by random gaps
    int burst_left = 1;
    int gap_left   = 0;

    always @(negedge aclk) begin
        logic      nv;
        pair_req_t nxt;
        if (aresetn && (!s_valid || took)) begin
            took = 1'b0;
            nv = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
            end else if (req_q.size() > 0) begin
                nxt = req_q.pop_front();
                nv = 1'b1;
                s_kind          <= nxt.kind;
                s_timing_offset <= nxt.offset;
                s_pulse_width   <= nxt.width;
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 12);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                end
            end
            s_valid <= nv;
        end
    end

    // Result receiver: the stall pattern is picked at random for each phase
    rx_mode_t rx_mode = RX_OPEN;
    int rx_phase_left = 0;
    int rx_tick       = 0;
    int hold_left     = 0;
    bit hold_done     = 1'b0;

    always @(negedge aclk) begin
        logic nr;
        rx_tick++;
        if (rx_phase_left == 0) begin
            rx_mode = rx_mode_t'($urandom_range(0, 2));
            rx_phase_left = $urandom_range(16, 96);
        end
        rx_phase_left--;
        // one long hold-off so the block backs up and drops s_ready
        if (!hold_done && taken_cnt >= 60) begin
            hold_left = LONG_HOLD;
            hold_done = 1'b1;
        end
        case (rx_mode)
            RX_OPEN:   nr = 1'b1;
            RX_RANDOM: nr = ($urandom_range(0, 9) >= 3);
            default:   nr = ((rx_tick % 3) != 0);
        endcase
        if (hold_left > 0) begin
            hold_left--;
            nr = 1'b0;
        end
        m_ready <= nr;
    end

    task automatic queue_request(logic kind, logic [15:0] off, logic [7:0] wid);
        req_q.push_back({kind, off, wid});
    endtask

    task automatic wait_drained();
        while (req_q.size() != 0 || s_valid || rows_due.size() != 0)
            @(posedge aclk);
    endtask

    initial begin
        pair_req_t pool[$];
        pair_req_t r;
        int k;
        int roll;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        queue_request(KIND_SORT, 16'h0000, 8'h00);     // dump of an empty table
        queue_request(KIND_ADD,  16'h0000, 8'h00);
        queue_request(KIND_ADD,  16'h0000, 8'h00);
        queue_request(KIND_ADD,  16'hFFFF, 8'hFF);
        queue_request(KIND_ADD,  16'hFFFF, 8'h00);
        queue_request(KIND_ADD,  16'h0000, 8'hFF);
        queue_request(KIND_ADD,  16'hFFFF, 8'hFF);
        queue_request(KIND_ADD,  16'hFFFF, 8'hFF);
        queue_request(KIND_ADD,  16'h5555, 8'hAA);
        queue_request(KIND_ADD,  16'hAAAA, 8'h55);
        queue_request(KIND_ADD,  16'h5555, 8'hAA);
        queue_request(KIND_SORT, 16'hFFFF, 8'hFF);
        queue_request(KIND_ADD,  16'h0000, 8'hFF);
        queue_request(KIND_ADD,  16'hAAAA, 8'h55);
        queue_request(KIND_ADD,  16'hAAAA, 8'h55);
        queue_request(KIND_SORT, 16'h1234, 8'h56);
        wait_drained();

        pool.push_back({KIND_ADD, 16'h0000, 8'h00});
        pool.push_back({KIND_ADD, 16'hFFFF, 8'hFF});
        for (k = 0; k < RANDOM_ITEMS; k++) begin
            if (k == RANDOM_ITEMS / 2)
                wait_drained();
            roll = $urandom_range(0, 99);
            if (roll < 8) begin
                r = {KIND_SORT, 16'($urandom), 8'($urandom)};
            end else if (roll < 55) begin
                // repeat a known pair, skewed toward a few hot ones
                if ($urandom_range(0, 1) == 0)
                    r = pool[$urandom_range(0, (pool.size() < 4) ? pool.size() - 1 : 3)];
                else
                    r = pool[$urandom_range(0, pool.size() - 1)];
            end else begin
                r = {KIND_ADD, 16'($urandom), 8'($urandom)};
                pool.push_back(r);
            end
            req_q.push_back(r);
        end
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (err_cnt == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
